### hw/rtl/pvbe_pkg.sv
// Types and constants shared by the plot vector byte encoder.
// Depends on nothing; every other file imports it.
package pvbe_pkg;

   localparam int CoordWidth = 12;
   localparam int DecWidth   = 5;
   localparam int ByteWidth  = 7;
   localparam int JobSlots   = 6;

   localparam logic [ByteWidth-1:0] GsByte  = 7'd29;
   localparam logic [ByteWidth-1:0] EscByte = 7'd27;
   localparam logic [ByteWidth-1:0] FfByte  = 7'd12;

   localparam logic [1:0] HighTag = 2'b01;
   localparam logic [1:0] LowYTag = 2'b11;
   localparam logic [1:0] LowXTag = 2'b10;
   localparam logic [2:0] ExtraTag = 3'b110;

   typedef enum logic [1:0] {
      FUNC_MOVE  = 2'd0,
      FUNC_DRAW  = 2'd1,
      FUNC_ERASE = 2'd2,
      FUNC_PEN   = 2'd3
   } func_type;

   typedef struct packed {
      func_type              func;
      logic [CoordWidth-1:0] x_coord;
      logic [CoordWidth-1:0] y_coord;
      logic                  pen_down;
   } req_item_type;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 last_byte;
   } rsp_item_type;

   // Slot order: lead byte, high-Y, extra, low-Y, high-X, low-X.
   typedef struct packed {
      logic [JobSlots-1:0]                mask;
      logic [JobSlots-1:0][ByteWidth-1:0] bytes;
   } job_type;

endpackage

### hw/rtl/pvbe_front.sv
// Front end: takes commands, scales points, compares with the remembered bytes.
// Pushes one byte job per command that emits anything. Uses pvbe_pkg.
module pvbe_front
   import pvbe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  req_item_type        req_item,
   input  logic                csr_wr_en,
   input  logic [DecWidth-1:0] csr_wr_data,
   input  logic                q_full,
   output logic                q_push,
   output job_type             q_job
);

   logic [DecWidth-1:0] dec_ff, dec_in;
   logic [4:0]          prev_hy_ff, prev_hy_in;
   logic [3:0]          prev_ex_ff, prev_ex_in;
   logic [4:0]          prev_ly_ff, prev_ly_in;
   logic [4:0]          prev_hx_ff, prev_hx_in;
   logic                hist_valid_ff, hist_valid_in;
   logic                pen_ff, pen_in;

   logic                           accept;
   logic [DecWidth-1:0]            factor;
   logic [CoordWidth+DecWidth-1:0] prod_x, prod_y;
   logic [CoordWidth-1:0]          sx, sy;
   logic [4:0]                     hy, ly, hx, lx;
   logic [3:0]                     ex;
   logic                           chg_hy, chg_ex, chg_ly, chg_hx;
   logic                           point, lead_gs;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_comb begin
      factor = (dec_ff == '0) ? DecWidth'(1) : dec_ff;
      prod_x = (CoordWidth+DecWidth)'(req_item.x_coord) * (CoordWidth+DecWidth)'(factor);
      prod_y = (CoordWidth+DecWidth)'(req_item.y_coord) * (CoordWidth+DecWidth)'(factor);
      sx     = prod_x[CoordWidth-1:0];
      sy     = prod_y[CoordWidth-1:0];
      hy     = sy[11:7];
      ly     = sy[6:2];
      hx     = sx[11:7];
      lx     = sx[6:2];
      ex     = {sy[1:0], sx[1:0]};
      chg_hy = !hist_valid_ff || (hy != prev_hy_ff);
      chg_ex = !hist_valid_ff || (ex != prev_ex_ff);
      chg_ly = ly != prev_ly_ff;
      chg_hx = !hist_valid_ff || (hx != prev_hx_ff);

      dec_in        = csr_wr_en ? csr_wr_data : dec_ff;
      prev_hy_in    = prev_hy_ff;
      prev_ex_in    = prev_ex_ff;
      prev_ly_in    = prev_ly_ff;
      prev_hx_in    = prev_hx_ff;
      hist_valid_in = hist_valid_ff;
      pen_in        = pen_ff;
      point         = 1'b0;
      lead_gs       = 1'b0;
      q_job         = '0;

      unique case (req_item.func)
         FUNC_MOVE: begin
            point   = 1'b1;
            lead_gs = 1'b1;
         end
         FUNC_DRAW: begin
            point = pen_ff;
         end
         FUNC_ERASE: begin
            q_job.bytes[0] = EscByte;
            q_job.bytes[1] = FfByte;
            q_job.mask     = 6'b000011;
            hist_valid_in  = 1'b0;
         end
         FUNC_PEN: begin
            pen_in = req_item.pen_down;
         end
         default: begin
            point = 1'b0;
         end
      endcase

      if (point) begin
         q_job.bytes[0] = GsByte;
         q_job.bytes[1] = {HighTag, hy};
         q_job.bytes[2] = {ExtraTag, ex};
         q_job.bytes[3] = {LowYTag, ly};
         q_job.bytes[4] = {HighTag, hx};
         q_job.bytes[5] = {LowXTag, lx};
         q_job.mask     = {1'b1, chg_hx, chg_ex || chg_ly || chg_hx, chg_ex, chg_hy, lead_gs};
         prev_hy_in     = hy;
         prev_ex_in     = ex;
         prev_ly_in     = ly;
         prev_hx_in     = hx;
         hist_valid_in  = 1'b1;
      end

      q_push = accept && (q_job.mask != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff        <= DecWidth'(1);
         prev_hy_ff    <= '0;
         prev_ex_ff    <= '0;
         prev_ly_ff    <= '0;
         prev_hx_ff    <= '0;
         hist_valid_ff <= 1'b0;
         pen_ff        <= 1'b1;
      end else begin
         dec_ff <= dec_in;
         if (accept) begin
            prev_hy_ff    <= prev_hy_in;
            prev_ex_ff    <= prev_ex_in;
            prev_ly_ff    <= prev_ly_in;
            prev_hx_ff    <= prev_hx_in;
            hist_valid_ff <= hist_valid_in;
            pen_ff        <= pen_in;
         end
      end
   end

endmodule

### hw/rtl/pvbe_queue.sv
// Short job queue between the front end and the byte sequencer.
// Register array with read and write pointers. Uses pvbe_pkg.
module pvbe_queue
   import pvbe_pkg::*;
#(
   parameter int Depth = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   job_type             mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = count_ff == CntWidth'(Depth);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntWidth'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(Depth))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + CntWidth'(1))
      else $error("queue count did not advance on push");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty |-> rd_ptr_ff == wr_ptr_ff)
      else $error("queue pointers differ while empty");

endmodule

### hw/rtl/pvbe_back.sv
// Byte sequencer: walks the slot mask of one job and emits one byte per cycle while
// its output register is free. Holds the result in an output register. Uses pvbe_pkg.
module pvbe_back
   import pvbe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  job_type      q_job,
   output logic         q_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_item_type rsp_item
);

   job_type      job_ff, job_in;
   logic         job_valid_ff, job_valid_in;
   rsp_item_type out_ff, out_in;
   logic         out_valid_ff, out_valid_in;

   logic                 out_free, emit, done, load;
   logic [JobSlots-1:0]  low, rest;
   logic [ByteWidth-1:0] sel;

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      out_free = !out_valid_ff || rsp_pop;
      emit     = job_valid_ff && out_free;
      low      = job_ff.mask & (~job_ff.mask + JobSlots'(1));
      rest     = job_ff.mask & ~low;
      done     = emit && (rest == '0);
      sel      = '0;
      for (int i = 0; i < JobSlots; i++) begin
         if (low[i]) begin
            sel = sel | job_ff.bytes[i];
         end
      end
      load  = !q_empty && (!job_valid_ff || done);
      q_pop = load;

      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      priority if (load) begin
         job_in       = q_job;
         job_valid_in = 1'b1;
      end else if (done) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         job_in.mask = rest;
      end else begin
         job_in = job_ff;
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      priority if (emit) begin
         out_in.out_byte  = sel;
         out_in.last_byte = rest == '0;
         out_valid_in     = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   a_job_nonzero: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> job_ff.mask != '0)
      else $error("active job has no bytes left");

   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !job_valid_ff) |-> out_ff.last_byte)
      else $error("sequencer idle before last byte of a job");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result waiting right after reset");

endmodule

### hw/rtl/plot_vector_byte_encoder_top.sv
// Plot vector byte encoder: front end, job queue and byte sequencer.
// Depends on pvbe_pkg, pvbe_front, pvbe_queue and pvbe_back.
//
// Input: push a plot command on req_item while req_full is low. Move, draw,
// erase and set-pen are decoded by the combinational front end; a command that
// emits bytes becomes one job of up to six bytes in the queue.
// Output: while rsp_empty is low, rsp_item holds the next byte of the stream;
// pop takes it. last_byte marks the final byte of each command.
// Path: an accepted job is written into the queue, loaded into the sequencer's
// job register, and its first byte then goes into the output register.
// Throughput: one byte per cycle while pop keeps up; a command emits one to six
// bytes, set-pen and pen-up draws none; the sequencer sets the sustained rate.
// Stall: when pop stays low the output register holds, the sequencer waits,
// the queue fills and req_full rises; decimation writes land at once.
// Reset: empties queue and output, pen down, history not sent, decimation 1.
module plot_vector_byte_encoder_top
   import pvbe_pkg::*;
#(
   parameter int QueueDepth = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  req_item_type        req_item,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_item_type        rsp_item,
   input  logic                csr_wr_en,
   input  logic [DecWidth-1:0] csr_wr_data
);

   logic    q_push, q_full, q_pop, q_empty;
   job_type q_push_job, q_pop_job;

   pvbe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (q_push_job)
   );

   pvbe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (q_pop_job),
      .empty    (q_empty)
   );

   pvbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (q_pop_job),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

### tb/tb_plot_vector_byte_encoder_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for plot_vector_byte_encoder_top: directed plot commands,
// then random phases at several decimation settings. Depends on pvbe_pkg and the RTL.
module tb_plot_vector_byte_encoder_top;
   import pvbe_pkg::*;

   typedef struct {
      req_item_type   item;
      logic [4:0]     dec;
      int             n_typed;
      logic [41:0]    typed;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   req_item_type        req_item = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   rsp_item_type        rsp_item;
   logic                csr_wr_en = 1'b0;
   logic [DecWidth-1:0] csr_wr_data = '0;

   int req_idle_pct = 19;
   int rsp_idle_pct = 74;
   int mismatch_count = 0;

   // predictor state
   logic [4:0] dec_setting = 5'd1;
   logic [4:0] sent_high_y = '0;
   logic [3:0] sent_extra = '0;
   logic [4:0] sent_low_y = '0;
   logic [4:0] sent_high_x = '0;
   logic       history_ok = 1'b0;
   logic       pen_state = 1'b1;

   logic [6:0]   cmd_bytes[$];
   rsp_item_type pending_bytes[$];
   plan_row_type plan[$];

   plot_vector_byte_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_item    (req_item),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void encode_point(input logic [11:0] xin, input logic [11:0] yin);
      logic [4:0]  f;
      logic [11:0] sx;
      logic [11:0] sy;
      logic [4:0]  hy;
      logic [3:0]  ex;
      logic [4:0]  ly;
      logic [4:0]  hx;
      logic [4:0]  lx;
      f  = (dec_setting == 5'd0) ? 5'd1 : dec_setting;
      sx = xin * f;
      sy = yin * f;
      hy = sy[11:7];
      ex = {sy[1:0], sx[1:0]};
      ly = sy[6:2];
      hx = sx[11:7];
      lx = sx[6:2];
      if (!history_ok || hy != sent_high_y)
         cmd_bytes.push_back(7'd32 + 7'(hy));
      if (!history_ok || ex != sent_extra) begin
         cmd_bytes.push_back(7'd96 + 7'(ex));
         cmd_bytes.push_back(7'd96 + 7'(ly));
      end else if (hx != sent_high_x || ly != sent_low_y) begin
         cmd_bytes.push_back(7'd96 + 7'(ly));
      end
      if (!history_ok || hx != sent_high_x)
         cmd_bytes.push_back(7'd32 + 7'(hx));
      cmd_bytes.push_back(7'd64 + 7'(lx));
      sent_high_y = hy;
      sent_extra  = ex;
      sent_low_y  = ly;
      sent_high_x = hx;
      history_ok  = 1'b1;
   endfunction

   function automatic void predict_command(input req_item_type it);
      cmd_bytes.delete();
      case (it.func)
         FUNC_MOVE: begin
            cmd_bytes.push_back(GsByte);
            encode_point(it.x_coord, it.y_coord);
         end
         FUNC_DRAW: begin
            if (pen_state)
               encode_point(it.x_coord, it.y_coord);
         end
         FUNC_ERASE: begin
            cmd_bytes.push_back(EscByte);
            cmd_bytes.push_back(FfByte);
            history_ok = 1'b0;
         end
         default: begin
            pen_state = it.pen_down;
         end
      endcase
   endfunction

   // drive one command, hold until accepted, then queue the bytes it should emit
   task automatic push_item(input req_item_type it, input int n_typed,
                            input logic [41:0] typed);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      predict_command(it);
      if (n_typed >= 0) begin
         cmd_bytes.delete();
         for (int i = 0; i < n_typed; i++)
            cmd_bytes.push_back(typed[(n_typed-1-i)*7 +: 7]);
      end
      foreach (cmd_bytes[i])
         pending_bytes.push_back('{out_byte: cmd_bytes[i],
                                   last_byte: (i == cmd_bytes.size() - 1)});
   endtask

   task automatic drain_stream();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_decimation(input logic [4:0] value);
      drain_stream();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      dec_setting = value;
   endtask

   task automatic add_row(input func_type f, input int x, input int y, input bit pen,
                          input int dec, input int n_typed, input logic [41:0] typed);
      plan_row_type row;
      row.item.func     = f;
      row.item.x_coord  = 12'(x);
      row.item.y_coord  = 12'(y);
      row.item.pen_down = pen;
      row.dec           = 5'(dec);
      row.n_typed       = n_typed;
      row.typed         = typed;
      plan.push_back(row);
   endtask

   always @(negedge clock)
      rsp_pop <= ($urandom_range(99) >= rsp_idle_pct);

   always @(posedge clock) begin : check_stream
      rsp_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected byte %0d last %0b", rsp_item.out_byte,
                        rsp_item.last_byte);
         end else begin
            want = pending_bytes.pop_front();
            if (want.out_byte !== rsp_item.out_byte ||
                want.last_byte !== rsp_item.last_byte) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected byte %0d last %0b, got byte %0d last %0b",
                           want.out_byte, want.last_byte, rsp_item.out_byte,
                           rsp_item.last_byte);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      req_item_type it;
      int           r;
      logic [11:0]  base_x;
      logic [11:0]  base_y;
      logic [4:0]   phase_dec[6];

      add_row(FUNC_MOVE,     0,    0, 0, 1, 6, {GsByte, 7'd32, 7'd96, 7'd96, 7'd32, 7'd64});
      add_row(FUNC_MOVE,     0,    0, 1, 1, 2, {GsByte, 7'd64});
      add_row(FUNC_DRAW,  4095, 4095, 0, 1, 5, {7'd63, 7'd111, 7'd127, 7'd63, 7'd95});
      add_row(FUNC_DRAW,  4095, 4095, 1, 1, 1, {7'd95});
      add_row(FUNC_DRAW,  4091, 4095, 0, 1, -1, '0);
      add_row(FUNC_DRAW,  4095,    3, 0, 1, -1, '0);
      add_row(FUNC_DRAW,   127,    3, 1, 1, -1, '0);
      add_row(FUNC_DRAW,   126,    2, 0, 1, -1, '0);
      add_row(FUNC_ERASE, 4095, 4095, 1, 1, 2, {EscByte, FfByte});
      add_row(FUNC_DRAW,     0,    0, 0, 1, 5, {7'd32, 7'd96, 7'd96, 7'd32, 7'd64});
      add_row(FUNC_PEN,   4095, 4095, 0, 1, 0, '0);
      add_row(FUNC_DRAW,   100,  200, 1, 1, 0, '0);
      add_row(FUNC_MOVE,  2048, 2048, 1, 1, -1, '0);
      add_row(FUNC_PEN,      0,    0, 1, 1, 0, '0);
      add_row(FUNC_DRAW,     1,    2, 0, 1, -1, '0);
      add_row(FUNC_ERASE,    0,    0, 0, 1, 2, {EscByte, FfByte});
      add_row(FUNC_MOVE,  4095,    0, 1, 1, 6, {GsByte, 7'd32, 7'd99, 7'd96, 7'd63, 7'd95});
      add_row(FUNC_MOVE,  4095,    0, 0, 0, 2, {GsByte, 7'd95});
      add_row(FUNC_DRAW,  4095, 4095, 1, 31, -1, '0);
      add_row(FUNC_DRAW,     1,    1, 0, 31, -1, '0);
      add_row(FUNC_MOVE,  4095, 4095, 1, 16, -1, '0);
      add_row(FUNC_DRAW,   256, 4095, 0, 16, -1, '0);
      add_row(FUNC_ERASE, 4095,    0, 1, 16, 2, {EscByte, FfByte});
      add_row(FUNC_DRAW,  2047,    1, 0, 16, -1, '0);

      phase_dec = '{5'd1, 5'd31, 5'd16, 5'd0, 5'd0, 5'd0};
      phase_dec[4] = 5'($urandom_range(2, 30));
      phase_dec[5] = 5'($urandom_range(2, 30));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].dec != dec_setting)
            set_decimation(plan[i].dec);
         push_item(plan[i].item, plan[i].n_typed, plan[i].typed);
      end

      base_x = '0;
      base_y = '0;
      for (int phase = 0; phase < 6; phase++) begin
         set_decimation(phase_dec[phase]);
         req_idle_pct = (phase < 2) ? 19 : (phase < 4) ? 74 : 0;
         rsp_idle_pct = (phase < 2) ? 74 : (phase < 4) ? 19 : 0;
         for (int n = 0; n < 75; n++) begin
            r = $urandom_range(99);
            it.func = (r < 18) ? FUNC_MOVE : (r < 78) ? FUNC_DRAW :
                      (r < 85) ? FUNC_ERASE : FUNC_PEN;
            it.pen_down = (it.func == FUNC_PEN) ? ($urandom_range(3) != 0)
                                                : 1'($urandom_range(1));
            case ($urandom_range(3))
               0: begin
                  it.x_coord = 12'($urandom_range(4095));
                  it.y_coord = 12'($urandom_range(4095));
               end
               1: begin
                  it.x_coord = base_x + 12'($urandom_range(16)) - 12'd8;
                  it.y_coord = base_y;
               end
               2: begin
                  it.x_coord = base_x + 12'($urandom_range(4)) - 12'd2;
                  it.y_coord = base_y + 12'($urandom_range(4)) - 12'd2;
               end
               default: begin
                  it.x_coord = base_x;
                  it.y_coord = base_y + 12'($urandom_range(256)) - 12'd128;
               end
            endcase
            if (it.func == FUNC_MOVE || it.func == FUNC_DRAW) begin
               base_x = it.x_coord;
               base_y = it.y_coord;
            end
            push_item(it, -1, '0);
         end
      end

      drain_stream();
      if (mismatch_count == 0 && pending_bytes.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
